>>> sv/natl_pkg.sv
// ----------------------------------------------------------------------------
// natl_pkg: shared types and constants
// Types, codes and protocol constants of the neighbor advertisement target
// link-layer address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package natl_pkg;

    // Field widths.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 12;
    localparam int unsigned OFF_W  = 5;
    localparam int unsigned OBL_W  = 11;
    localparam int unsigned ADDR_W = 64;

    // ICMPv6 constants.
    localparam int unsigned         HDR_BYTES      = 24;
    localparam int unsigned         TARGET_START   = 8;
    localparam logic [BYTE_W-1:0]   NA_TYPE        = 8'd136;
    localparam logic [BYTE_W-1:0]   NA_CODE        = 8'd0;
    localparam logic [BYTE_W-1:0]   TLLA_TYPE      = 8'd2;
    localparam int unsigned         MIN_OPT_BYTES  = 8;
    localparam int unsigned         OPT_UNIT_SHIFT = 3;
    localparam int unsigned         OPT_HDR_BYTES  = 2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_HIGH = 1'b0,
        CFG_TARGET_LOW  = 1'b1
    } cfg_idx_t;

    // Result queue geometry.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_OPT_TYPE,
        PH_OPT_LEN,
        PH_SKIP,
        PH_EMIT,
        PH_DONE
    } phase_t;

    typedef enum logic {
        RK_ADDR    = 1'b0,
        RK_VERDICT = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_byte;
        logic              first_byte;
        logic [LEN_W-1:0]  msg_length;
        logic              last_byte;
    } msg_item_t;

    typedef struct packed {
        result_kind_t      result_kind;
        logic [BYTE_W-1:0] addr_byte;
        logic              found;
        logic              last;
    } result_t;

    // Results produced by one parse step, pushed into the result queue.
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] emit_byte;
        logic              verdict;
        logic              found;
    } push_t;

    typedef struct packed {
        logic                  room2;
        logic [FIFO_CNT_W-1:0] level;
    } fifo_stat_t;

endpackage

`default_nettype wire

>>> sv/natl_msg_if.sv
// ----------------------------------------------------------------------------
// natl_msg_if: message byte channel
// Valid/ready channel that carries one ICMPv6 message byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface natl_msg_if;
    logic                          valid;
    logic                          ready;
    logic [natl_pkg::BYTE_W-1:0]   msg_byte;
    logic                          first_byte;
    logic [natl_pkg::LEN_W-1:0]    msg_length;
    logic                          last_byte;

    modport source (output valid, msg_byte, first_byte, msg_length, last_byte,
                    input ready);
    modport sink   (input valid, msg_byte, first_byte, msg_length, last_byte,
                    output ready);
endinterface

`default_nettype wire

>>> sv/natl_res_if.sv
// ----------------------------------------------------------------------------
// natl_res_if: result channel
// Valid/ready channel that carries one address byte or verdict per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface natl_res_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [natl_pkg::BYTE_W-1:0]   addr_byte;
    logic                          found;
    logic                          last;

    modport source (output valid, result_kind, addr_byte, found, last,
                    input ready);
    modport sink   (input valid, result_kind, addr_byte, found, last,
                    output ready);
endinterface

`default_nettype wire

>>> sv/nd_advert_target_lladdr_parser.sv
// ----------------------------------------------------------------------------
// nd_advert_target_lladdr_parser: ND advertisement target link-layer parser
// Checks an ICMPv6 neighbor advertisement against a configured target and
// returns the payload of its first target link-layer address option.
// ----------------------------------------------------------------------------
// Usage: message bytes enter on msg_in, one per transaction, with first_byte
// and msg_length on the opening byte and last_byte on the closing one. Each
// payload byte of the first type 2 option leaves on res_out as an address
// result; the closing byte also produces a verdict result with last set.
// The target address is written through cfg_we/cfg_index/cfg_data while no
// message is in flight.
// Throughput is one byte per cycle unless the queue lacks room: each byte
// passes an input register and one parse step, which keeps a single byte of
// parser state update. Results are stored in the result queue before they are
// offered. A closing byte that also carries an address byte puts two results
// into the four-entry result queue; they leave on consecutive transactions.
// When res_out stalls, the queue fills and msg_in.ready drops once fewer than
// two entries are free. Reset empties the queue and returns the parser to the
// header phase with no message started; the target address resets to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nd_advert_target_lladdr_parser #(
    parameter int unsigned MAX_MESSAGE_BYTES = 2048
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    natl_msg_if.sink                                msg_in,
    natl_res_if.source                              res_out,
    input  wire logic                               cfg_we,
    input  wire logic [natl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [natl_pkg::ADDR_W-1:0]        cfg_data
);

    natl_pkg::push_t        push;
    natl_pkg::fifo_stat_t   fifo_st;

    natl_core #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fifo_st   (fifo_st),
        .push      (push)
    );

    natl_res_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .fifo_st (fifo_st),
        .res     (res_out)
    );

`ifndef SYNTHESIS
    // The parser never pushes into a queue that lacks room for both results.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.emit || push.verdict) |-> fifo_st.room2)
        else $error("result pushed without room in the queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fifo_st.level) <= natl_pkg::FIFO_DEPTH)
        else $error("result queue level exceeds its depth");

    a_verdict_out: assert property (@(posedge clk) disable iff (!rst_n)
        push.verdict |=> res_out.valid)
        else $error("verdict pushed but no result offered");

    a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push.emit && push.verdict && !(res_out.valid && res_out.ready))
        |=> 32'(fifo_st.level) >= 2)
        else $error("two results pushed but queue level too low");
`endif

endmodule

`default_nettype wire

>>> sv/natl_core.sv
// ----------------------------------------------------------------------------
// natl_core: input register and parse step
// Registers each message byte, then runs one step of the header check and
// option walk, updating the parser state and producing up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module natl_core #(
    parameter int unsigned MAX_MESSAGE_BYTES = 2048
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    natl_msg_if.sink                                msg,
    input  wire logic                               cfg_we,
    input  wire logic [natl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [natl_pkg::ADDR_W-1:0]        cfg_data,
    input  wire natl_pkg::fifo_stat_t               fifo_st,
    output natl_pkg::push_t                         push
);

    logic                                 s1_valid_reg;
    natl_pkg::msg_item_t                  s1_item_reg;
    logic [natl_pkg::ADDR_W-1:0]          tgt_high_reg;
    logic [natl_pkg::ADDR_W-1:0]          tgt_low_reg;

    natl_pkg::phase_t                     phase_reg, phase_next;
    logic [natl_pkg::OFF_W-1:0]           off_reg, off_next;
    logic [natl_pkg::LEN_W-1:0]           rem_reg, rem_next;
    logic [natl_pkg::OBL_W-1:0]           obl_reg, obl_next;
    logic [natl_pkg::BYTE_W-1:0]          otype_reg, otype_next;
    logic                                 hm_reg, hm_next;
    logic                                 af_reg, af_next;

    logic                                 fire;
    logic [natl_pkg::LEN_W-1:0]           len_clamped;
    logic [natl_pkg::OFF_W-1:0]           off_cur;
    logic [2*natl_pkg::ADDR_W-1:0]        tgt;
    logic [3:0]                           tgt_idx;
    logic [natl_pkg::BYTE_W-1:0]          tgt_byte;
    logic [natl_pkg::OBL_W-1:0]           optlen;
    logic [natl_pkg::LEN_W:0]             avail;
    logic [natl_pkg::BYTE_W-1:0]          b;

    // A step runs only when the result queue can take both possible results.
    assign fire      = s1_valid_reg && fifo_st.room2;
    assign msg.ready = !s1_valid_reg || fire;
    assign b         = s1_item_reg.msg_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.valid && msg.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            s1_item_reg.msg_byte   <= msg.msg_byte;
            s1_item_reg.first_byte <= msg.first_byte;
            s1_item_reg.msg_length <= msg.msg_length;
            s1_item_reg.last_byte  <= msg.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_high_reg <= '0;
            tgt_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (natl_pkg::cfg_idx_t'(cfg_index))
                natl_pkg::CFG_TARGET_HIGH: tgt_high_reg <= cfg_data;
                natl_pkg::CFG_TARGET_LOW:  tgt_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The offset of the byte in hand; an opening byte always sits at offset zero.
    assign off_cur = s1_item_reg.first_byte ? '0 : off_reg;

    // Expected target byte for header offsets 8 to 23, big endian.
    assign tgt      = {tgt_high_reg, tgt_low_reg};
    assign tgt_idx  = 4'(off_cur - natl_pkg::OFF_W'(natl_pkg::TARGET_START));
    assign tgt_byte = tgt[8*(4'd15 - tgt_idx) +: natl_pkg::BYTE_W];

    always_comb
    begin
        if (32'(s1_item_reg.msg_length) > MAX_MESSAGE_BYTES)
        begin
            len_clamped = natl_pkg::LEN_W'(MAX_MESSAGE_BYTES);
        end
        else
        begin
            len_clamped = s1_item_reg.msg_length;
        end
    end

    // The length byte is never an opening byte, so the registered count applies.
    assign optlen = {b, 3'b000};
    assign avail  = {1'b0, rem_reg} + 13'd1;

    always_comb
    begin
        phase_next = phase_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        obl_next   = obl_reg;
        otype_next = otype_reg;
        hm_next    = hm_reg;
        af_next    = af_reg;
        push       = '0;

        if (s1_item_reg.first_byte)
        begin
            phase_next = natl_pkg::PH_HEADER;
            off_next   = '0;
            rem_next   = len_clamped;
            obl_next   = '0;
            otype_next = '0;
            hm_next    = (32'(len_clamped) >= natl_pkg::HDR_BYTES);
            af_next    = 1'b0;
        end

        if (rem_next != '0)
        begin
            case (phase_next)
                natl_pkg::PH_HEADER:
                begin
                    if (off_cur == 5'd0 && b != natl_pkg::NA_TYPE)
                    begin
                        hm_next = 1'b0;
                    end
                    else if (off_cur == 5'd1 && b != natl_pkg::NA_CODE)
                    begin
                        hm_next = 1'b0;
                    end
                    else if (32'(off_cur) >= natl_pkg::TARGET_START
                             && 32'(off_cur) < natl_pkg::HDR_BYTES
                             && b != tgt_byte)
                    begin
                        hm_next = 1'b0;
                    end
                    off_next = off_next + 5'd1;
                    rem_next = rem_next - 12'd1;
                    if (32'(off_next) >= natl_pkg::HDR_BYTES)
                    begin
                        phase_next = hm_next ? natl_pkg::PH_OPT_TYPE : natl_pkg::PH_DONE;
                    end
                end
                natl_pkg::PH_OPT_TYPE:
                begin
                    if (32'(rem_next) < natl_pkg::MIN_OPT_BYTES)
                    begin
                        phase_next = natl_pkg::PH_DONE;
                    end
                    else
                    begin
                        otype_next = b;
                        rem_next   = rem_next - 12'd1;
                        phase_next = natl_pkg::PH_OPT_LEN;
                    end
                end
                natl_pkg::PH_OPT_LEN:
                begin
                    // The remaining count already excludes the type byte.
                    if (optlen == '0 || {2'b00, optlen} > avail)
                    begin
                        phase_next = natl_pkg::PH_DONE;
                    end
                    else
                    begin
                        rem_next = rem_next - 12'd1;
                        obl_next = optlen - natl_pkg::OBL_W'(natl_pkg::OPT_HDR_BYTES);
                        if (otype_next == natl_pkg::TLLA_TYPE)
                        begin
                            af_next    = 1'b1;
                            phase_next = natl_pkg::PH_EMIT;
                        end
                        else
                        begin
                            phase_next = natl_pkg::PH_SKIP;
                        end
                    end
                end
                natl_pkg::PH_SKIP:
                begin
                    rem_next = rem_next - 12'd1;
                    if (obl_next != '0)
                    begin
                        obl_next = obl_next - 11'd1;
                    end
                    if (obl_next == '0)
                    begin
                        phase_next = natl_pkg::PH_OPT_TYPE;
                    end
                end
                natl_pkg::PH_EMIT:
                begin
                    rem_next       = rem_next - 12'd1;
                    push.emit      = fire;
                    push.emit_byte = b;
                    if (obl_next != '0)
                    begin
                        obl_next = obl_next - 11'd1;
                    end
                    if (obl_next == '0)
                    begin
                        phase_next = natl_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        end

        if (s1_item_reg.last_byte)
        begin
            push.verdict = fire;
            push.found   = hm_next && af_next;
            phase_next   = natl_pkg::PH_DONE;
            rem_next     = '0;
            obl_next     = '0;
            af_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= natl_pkg::PH_HEADER;
            off_reg   <= '0;
            rem_reg   <= '0;
            obl_reg   <= '0;
            otype_reg <= '0;
            hm_reg    <= 1'b1;
            af_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
            obl_reg   <= obl_next;
            otype_reg <= otype_next;
            hm_reg    <= hm_next;
            af_reg    <= af_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/natl_res_fifo.sv
// ----------------------------------------------------------------------------
// natl_res_fifo: result queue
// Four-entry queue that takes up to two results per cycle and presents them
// one per transaction on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module natl_res_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire natl_pkg::push_t        push,
    output natl_pkg::fifo_stat_t        fifo_st,
    natl_res_if.source                  res
);

    natl_pkg::result_t                        mem [natl_pkg::FIFO_DEPTH];
    logic [natl_pkg::FIFO_PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [natl_pkg::FIFO_PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [natl_pkg::FIFO_CNT_W-1:0]          cnt_reg, cnt_next;
    logic [natl_pkg::FIFO_PTR_W-1:0]          verdict_ptr;
    logic                                     pop;
    natl_pkg::result_t                        emit_ent;
    natl_pkg::result_t                        verdict_ent;
    natl_pkg::result_t                        head;

    assign pop         = res.valid && res.ready;
    assign verdict_ptr = wr_ptr_reg + natl_pkg::FIFO_PTR_W'(push.emit);

    always_comb
    begin
        emit_ent.result_kind    = natl_pkg::RK_ADDR;
        emit_ent.addr_byte      = push.emit_byte;
        emit_ent.found          = 1'b0;
        emit_ent.last           = 1'b0;
        verdict_ent.result_kind = natl_pkg::RK_VERDICT;
        verdict_ent.addr_byte   = '0;
        verdict_ent.found       = push.found;
        verdict_ent.last        = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push.emit)
        begin
            mem[wr_ptr_reg] <= emit_ent;
        end
        if (push.verdict)
        begin
            mem[verdict_ptr] <= verdict_ent;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + natl_pkg::FIFO_PTR_W'(push.emit)
                                 + natl_pkg::FIFO_PTR_W'(push.verdict);
        rd_ptr_next = rd_ptr_reg + natl_pkg::FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + natl_pkg::FIFO_CNT_W'(push.emit)
                              + natl_pkg::FIFO_CNT_W'(push.verdict)
                              - natl_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head            = mem[rd_ptr_reg];
    assign res.valid       = (cnt_reg != '0);
    assign res.result_kind = head.result_kind;
    assign res.addr_byte   = head.addr_byte;
    assign res.found       = head.found;
    assign res.last        = head.last;

    // Room for two is judged on the registered count, ignoring a same-cycle pop.
    assign fifo_st.room2 = (32'(cnt_reg) <= natl_pkg::FIFO_DEPTH - 2);
    assign fifo_st.level = cnt_reg;

endmodule

`default_nettype wire
